>>> hw/rtl/nps_pkg.sv
// package with shared types and constants of the priority scheduler
`default_nettype none
package nps_pkg;

    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int NUM_W   = 5;
    localparam int TIME_W  = 21;
    localparam int IN_W    = ARR_W + BURST_W + PRIO_W;
    localparam int OUT_W   = 72;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PUT
    } t_state;

    // selection packet handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic               pending;
        logic [ARR_W-1:0]   earliest;
    } t_scan_pkt;

    typedef struct packed {
        logic               load_we;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_load;

    typedef struct packed {
        logic clear;
        logic fin_we;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> hw/rtl/nps_cell.sv
// one process entry of the scheduler chain with its stage of the selection scan
`default_nettype none
module nps_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  nps_pkg::t_load                i_load,
    input  nps_pkg::t_cell_ctl            i_ctl,
    input  wire  [IDX_W-1:0]              i_fin_idx,
    input  wire  [nps_pkg::TIME_W-1:0]    i_time,
    input  nps_pkg::t_scan_pkt            i_pkt,
    input  wire  [IDX_W-1:0]              i_idx,
    output nps_pkg::t_scan_pkt            o_pkt,
    output logic [IDX_W-1:0]              o_idx
);

    logic [nps_pkg::ARR_W-1:0]   r_arr;
    logic [nps_pkg::BURST_W-1:0] r_burst;
    logic [nps_pkg::PRIO_W-1:0]  r_prio;
    logic                        r_loaded;
    logic                        r_fin;
    nps_pkg::t_scan_pkt          r_pkt;
    nps_pkg::t_scan_pkt          n_pkt;
    logic [IDX_W-1:0]            r_idx;
    logic [IDX_W-1:0]            n_idx;

    logic eligible;
    logic arrived;
    logic better;

    always_ff @(posedge i_clk) begin
        if (i_load.load_we) begin
            r_arr   <= i_load.arrival;
            r_burst <= i_load.burst;
            r_prio  <= i_load.prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_fin    <= 1'b0;
        end else if (i_ctl.clear) begin
            r_loaded <= 1'b0;
            r_fin    <= 1'b0;
        end else begin
            if (i_load.load_we) begin
                r_loaded <= 1'b1;
                r_fin    <= 1'b0;
            end else if (i_ctl.fin_we && (i_fin_idx == IDX_W'(CELL_IDX))) begin
                r_fin <= 1'b1;
            end
        end
    end

    always_comb begin
        eligible = r_loaded && !r_fin;
        arrived  = ({{(nps_pkg::TIME_W-nps_pkg::ARR_W){1'b0}}, r_arr} <= i_time);
        better   = !i_pkt.found || (r_prio > i_pkt.prio) ||
                   ((r_prio == i_pkt.prio) && (r_arr < i_pkt.arrival));
        n_pkt = i_pkt;
        n_idx = i_idx;
        if (eligible && (!i_pkt.pending || (r_arr < i_pkt.earliest))) begin
            n_pkt.earliest = r_arr;
        end
        if (eligible) begin
            n_pkt.pending = 1'b1;
        end
        if (eligible && arrived && better) begin
            n_pkt.found   = 1'b1;
            n_pkt.arrival = r_arr;
            n_pkt.burst   = r_burst;
            n_pkt.prio    = r_prio;
            n_idx         = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt <= '0;
            r_idx <= '0;
        end else begin
            r_pkt <= n_pkt;
            r_idx <= n_idx;
        end
    end

    assign o_pkt = r_pkt;
    assign o_idx = r_idx;

endmodule
`default_nettype wire

>>> hw/rtl/nonpreemptive_priority_scheduler.sv
// top level of the non-preemptive priority scheduler with its control sequencer
//
// Processes stream in one per cycle (arrival, burst, priority); up to MAX_PROCS are kept,
// further ones are dropped. The transfer marked tlast starts scheduling from time zero and
// the input is held off until the set is done. Each decision sends one selection packet
// down the row of MAX_PROCS cells, one cell per cycle, and a found entry waits in place while
// the result port is busy; a jump over an idle gap costs one more scan.
// Results leave in completion order, the final one marked by tlast.
`default_nettype none
module nonpreemptive_priority_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // arrival_time, burst_time, priority_level
    input  wire  [nps_pkg::IN_W-1:0]     s_axis_tdata,
    input  wire                          s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // process_number, completion_time, turnaround_time, waiting_time, zero pad
    output logic [nps_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic                         m_axis_tlast
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int TW    = nps_pkg::TIME_W;

    nps_pkg::t_state      r_state;
    nps_pkg::t_state      n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     r_done;
    logic [CNT_W-1:0]     n_done;
    logic [TW-1:0]        r_time;
    logic [TW-1:0]        n_time;
    logic                 r_go;
    logic                 n_go;
    nps_pkg::t_scan_pkt   r_sel;
    logic [IDX_W-1:0]     r_sel_idx;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_out_last;
    logic [nps_pkg::OUT_W-1:0] r_out_data;

    nps_pkg::t_scan_pkt   chain_pkt [MAX_PROCS+1];
    logic [IDX_W-1:0]     chain_idx [MAX_PROCS+1];
    nps_pkg::t_load       load_bus  [MAX_PROCS];
    nps_pkg::t_cell_ctl   cell_ctl;

    logic                 in_xfer;
    logic                 load_wr;
    logic                 out_free;
    logic                 commit;
    logic                 set_last;
    logic [TW:0]          sum;
    logic [TW-1:0]        ct;
    logic [TW-1:0]        tat;
    logic [TW-1:0]        wt;
    logic [31:0]          num32;
    logic [CNT_W-1:0]     done_inc;

    assign s_axis_tready = (r_state == nps_pkg::ST_LOAD);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign load_wr       = in_xfer && (r_count < CNT_W'(MAX_PROCS));
    assign out_free      = !r_out_valid || m_axis_tready;
    assign done_inc      = r_done + CNT_W'(1);
    assign set_last      = (done_inc == r_count);

    // result arithmetic on the chosen entry
    always_comb begin
        sum   = {1'b0, r_time} + {{(TW+1-nps_pkg::BURST_W){1'b0}}, r_sel.burst};
        ct    = (sum > {1'b0, nps_pkg::TIME_MAX}) ? nps_pkg::TIME_MAX : sum[TW-1:0];
        tat   = ct - {{(TW-nps_pkg::ARR_W){1'b0}}, r_sel.arrival};
        wt    = (tat >= {{(TW-nps_pkg::BURST_W){1'b0}}, r_sel.burst}) ?
                (tat - {{(TW-nps_pkg::BURST_W){1'b0}}, r_sel.burst}) : '0;
        num32 = 32'(r_sel_idx) + 32'd1;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_done      = r_done;
        n_time      = r_time;
        n_go        = 1'b0;
        n_out_valid = r_out_valid && !m_axis_tready;
        commit      = 1'b0;
        cell_ctl    = '0;
        unique case (r_state)
            nps_pkg::ST_LOAD: begin
                if (load_wr) begin
                    n_count = r_count + CNT_W'(1);
                end
                if (in_xfer && s_axis_tlast && (n_count != '0)) begin
                    n_time  = '0;
                    n_done  = '0;
                    n_go    = 1'b1;
                    n_state = nps_pkg::ST_SCAN;
                end
            end
            nps_pkg::ST_SCAN: begin
                if (chain_pkt[MAX_PROCS].valid) begin
                    n_state = nps_pkg::ST_PUT;
                end
            end
            nps_pkg::ST_PUT: begin
                if (!r_sel.found) begin
                    n_time  = {{(TW-nps_pkg::ARR_W){1'b0}}, r_sel.earliest};
                    n_go    = 1'b1;
                    n_state = nps_pkg::ST_SCAN;
                end else if (out_free) begin
                    commit          = 1'b1;
                    n_out_valid     = 1'b1;
                    cell_ctl.fin_we = 1'b1;
                    n_time          = ct;
                    n_done          = done_inc;
                    if (set_last) begin
                        cell_ctl.clear = 1'b1;
                        n_count        = '0;
                        n_time         = '0;
                        n_state        = nps_pkg::ST_LOAD;
                    end else begin
                        n_go    = 1'b1;
                        n_state = nps_pkg::ST_SCAN;
                    end
                end
            end
            default: n_state = nps_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nps_pkg::ST_LOAD;
            r_count     <= '0;
            r_done      <= '0;
            r_time      <= '0;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_done      <= n_done;
            r_time      <= n_time;
            r_go        <= n_go;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == nps_pkg::ST_SCAN) && chain_pkt[MAX_PROCS].valid) begin
            r_sel     <= chain_pkt[MAX_PROCS];
            r_sel_idx <= chain_idx[MAX_PROCS];
        end
        if (commit) begin
            r_out_data <= {4'b0000, wt, tat, ct, num32[nps_pkg::NUM_W-1:0]};
            r_out_last <= set_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // packet injected at the head of the chain
    always_comb begin
        chain_pkt[0]       = '0;
        chain_pkt[0].valid = r_go;
        chain_idx[0]       = '0;
    end

    for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
        always_comb begin
            load_bus[g].load_we = load_wr && (r_count == CNT_W'(g));
            load_bus[g].arrival = s_axis_tdata[nps_pkg::ARR_W-1:0];
            load_bus[g].burst   = s_axis_tdata[nps_pkg::ARR_W+nps_pkg::BURST_W-1:
                                               nps_pkg::ARR_W];
            load_bus[g].prio    = s_axis_tdata[nps_pkg::IN_W-1:
                                               nps_pkg::ARR_W+nps_pkg::BURST_W];
        end

        nps_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (load_bus[g]),
            .i_ctl     (cell_ctl),
            .i_fin_idx (r_sel_idx),
            .i_time    (r_time),
            .i_pkt     (chain_pkt[g]),
            .i_idx     (chain_idx[g]),
            .o_pkt     (chain_pkt[g+1]),
            .o_idx     (chain_idx[g+1])
        );
    end

endmodule
`default_nettype wire
